[rtl/fama_pkg.sv]
// Package with types, constants and sequencer states of the filtered adaptive average.
package fama_pkg;

    localparam int LOOKBACK_BARS_DEF = 14;
    localparam int SLOW_BARS_DEF     = 30;
    localparam int BAND_BARS_DEF     = 4;

    localparam logic [15:0] FAST_COEFF_RST  = 16'd43691;
    localparam logic [15:0] SLOW_COEFF_RST  = 16'd4228;
    localparam logic [31:0] BAND_MARGIN_RST = 32'd50;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_COEFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_COEFF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_MARGIN = 2'd2;

    typedef struct packed {
        logic [31:0] close_price;
        logic [31:0] high_price;
        logic [31:0] low_price;
    } t_in_beat;

    typedef struct packed {
        logic [47:0] raw_average;
        logic [47:0] filtered_average;
        logic        trend_flag;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE, ST_NOISE0, ST_NOISE, ST_DIV, ST_LIN, ST_SQ, ST_MLO, ST_MHI,
        ST_UPD, ST_SUM0, ST_SUM, ST_SMALL, ST_BAND, ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        MSEL_LIN, MSEL_SQ, MSEL_LO, MSEL_HI
    } t_msel;

    typedef struct packed {
        logic  rot_close;
        logic  rot_raw;
        logic  rot_band;
        logic  acc_load;
        logic  acc_add;
        t_msel msel;
    } t_ctrl;

endpackage

[rtl/filtered_adaptive_moving_average.sv]
// Top level of the filtered Kaufman adaptive moving average with its sequencer and datapath.
// A warmup bar goes straight to the result beat; a computed bar first sweeps the close
// history through one abs-diff unit and runs the 17-step divider, and a filtered bar then
// also sweeps the raw-average and band histories.
// Throughput: one bar at a time; the input stalls until the sequencer has loaded the result.
// Reset (synchronous, active low) clears histories, averages, flag and warmup count; loads config.
module filtered_adaptive_moving_average
    import fama_pkg::*;
#(
    parameter int LOOKBACK_BARS = LOOKBACK_BARS_DEF,
    parameter int SLOW_BARS     = SLOW_BARS_DEF,
    parameter int BAND_BARS     = BAND_BARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    // Widths derived from the history depths.
    localparam int NW    = 32 + $clog2(LOOKBACK_BARS);       // noise sum
    localparam int AW    = 48 + $clog2(SLOW_BARS);           // shared accumulator
    localparam int MAXD  = (LOOKBACK_BARS > SLOW_BARS) ?
                           ((LOOKBACK_BARS > BAND_BARS) ? LOOKBACK_BARS : BAND_BARS) :
                           ((SLOW_BARS > BAND_BARS) ? SLOW_BARS : BAND_BARS);
    // The counter also steps the divider down from 16.
    localparam int CNTW  = $clog2(((MAXD > 16) ? MAXD : 16) + 1);
    localparam int WUW   = $clog2(LOOKBACK_BARS + 2);
    localparam int SMW   = 64;
    localparam logic [WUW-1:0] WU_LIM = WUW'(LOOKBACK_BARS);

    // Configuration registers.
    logic [15:0] r_fast, r_slow;
    logic [31:0] r_margin;

    // Histories. Index 0 holds the newest entry; during a sweep each array rotates so that
    // entries 0 and 1 present every neighboring pair in turn and return home at the end.
    logic [31:0] r_ch [LOOKBACK_BARS];
    logic [47:0] r_rh [SLOW_BARS];
    logic [31:0] r_hh [BAND_BARS];
    logic [31:0] r_lh [BAND_BARS];

    logic [47:0]    r_filt;
    logic           r_flag;
    logic [WUW-1:0] r_warm;

    t_state r_state, n_state;
    t_ctrl  ctrl;

    t_in_beat     r_bar;
    logic [CNTW-1:0] r_cnt;
    logic [AW-1:0]   r_acc;
    logic [NW-1:0]   r_noise, r_rem;
    logic [31:0]     r_signal;
    logic [16:0]     r_quo;
    logic [31:0]     r_lin;
    logic [16:0]     r_sc;
    logic [47:0]     r_mag;
    logic            r_up;
    logic [40:0]     r_pp_lo, r_pp_hi;
    logic [47:0]     r_new;
    logic            r_filter_on;
    logic [47:0]     r_ad;
    logic            r_small;
    logic [31:0]     r_maxh, r_minl;
    logic            r_out_valid;
    t_out_beat       r_out;

    logic in_fire, out_free;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared absolute-difference unit feeding the accumulator.
    logic [47:0] ad_a, ad_b, ad_out;
    always_comb begin
        unique case (r_state)
            ST_NOISE0: begin
                ad_a = {16'd0, r_bar.close_price};
                ad_b = {16'd0, r_ch[0]};
            end
            ST_NOISE: begin
                ad_a = {16'd0, r_ch[0]};
                ad_b = {16'd0, r_ch[(LOOKBACK_BARS > 1) ? 1 : 0]};
            end
            ST_SUM0: begin
                ad_a = r_new;
                ad_b = r_rh[0];
            end
            default: begin
                ad_a = r_rh[0];
                ad_b = r_rh[(SLOW_BARS > 1) ? 1 : 0];
            end
        endcase
        ad_out = (ad_a > ad_b) ? (ad_a - ad_b) : (ad_b - ad_a);
    end

    // Shared signed multiplier: ER times spread, the square of the linear constant, and the
    // two 24-bit halves of the step magnitude times the smoothing constant.
    logic signed [32:0] m_a, m_b;
    logic signed [65:0] m_p;
    logic signed [16:0] spread;
    assign spread = $signed({1'b0, r_fast}) - $signed({1'b0, r_slow});
    always_comb begin
        unique case (ctrl.msel)
            MSEL_LIN: begin
                m_a = $signed({16'd0, r_quo});
                m_b = 33'(spread);
            end
            MSEL_SQ: begin
                m_a = $signed({1'b0, r_lin});
                m_b = $signed({1'b0, r_lin});
            end
            MSEL_LO: begin
                m_a = $signed({9'd0, r_mag[23:0]});
                m_b = $signed({16'd0, r_sc});
            end
            MSEL_HI: begin
                m_a = $signed({9'd0, r_mag[47:24]});
                m_b = $signed({16'd0, r_sc});
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
    end

    // Divider step: one quotient bit per cycle, top bit first.
    logic [NW:0] rem2;
    assign rem2 = {r_rem, (r_cnt == CNTW'(16)) ? r_signal[0] : 1'b0};

    // Rounded square and step update.
    logic [64:0] sq_rnd;
    logic [64:0] step_tot;
    logic [48:0] step;
    assign sq_rnd   = {1'b0, m_p[63:0]} + (65'd1 << 47);
    assign step_tot = {r_pp_hi, 24'd0} + 65'(r_pp_lo) + 65'd32768;
    assign step     = step_tot[64:16];

    // Freeze test: |d| * 100 * SLOW_BARS < 50 * sum, reduced to 2 * SLOW_BARS * |d| < sum.
    logic [SMW-1:0] ad_scaled;
    assign ad_scaled = SMW'(r_ad) * SMW'(2 * SLOW_BARS);

    // Filter decision and trend flag.
    logic [47:0] filt;
    logic [32:0] hi_lim, lo_lim;
    assign hi_lim = {1'b0, r_maxh} + {1'b0, r_margin};
    assign lo_lim = {1'b0, r_bar.low_price} + {1'b0, r_margin};
    always_comb begin
        filt = r_new;
        if (r_filter_on && r_small) begin
            if (r_new > r_rh[0]) begin
                if ({1'b0, r_bar.high_price} <= hi_lim) filt = r_filt;
            end else if (r_new < r_rh[0]) begin
                if (lo_lim >= {1'b0, r_minl}) filt = r_filt;
            end
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_fire) n_state = (r_warm < WU_LIM) ? ST_FIN : ST_NOISE0;
            ST_NOISE0: n_state = ST_NOISE;
            ST_NOISE:  if (r_cnt == CNTW'(LOOKBACK_BARS - 1)) n_state = ST_DIV;
            ST_DIV:    if (r_cnt == '0) n_state = ST_LIN;
            ST_LIN:    n_state = ST_SQ;
            ST_SQ:     n_state = ST_MLO;
            ST_MLO:    n_state = ST_MHI;
            ST_MHI:    n_state = ST_UPD;
            ST_UPD:    n_state = (r_warm > WU_LIM) ? ST_SUM0 : ST_FIN;
            ST_SUM0:   n_state = ST_SUM;
            ST_SUM:    if (r_cnt == CNTW'(SLOW_BARS - 1)) n_state = ST_SMALL;
            ST_SMALL:  n_state = ST_BAND;
            ST_BAND:   if (r_cnt == CNTW'(BAND_BARS - 1)) n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        ctrl = '0;
        ctrl.msel = MSEL_LIN;
        unique case (r_state)
            ST_NOISE0: ctrl.acc_load = 1'b1;
            ST_NOISE: begin
                ctrl.rot_close = 1'b1;
                ctrl.acc_add   = (r_cnt != CNTW'(LOOKBACK_BARS - 1));
            end
            ST_SQ:     ctrl.msel = MSEL_SQ;
            ST_MLO:    ctrl.msel = MSEL_LO;
            ST_MHI:    ctrl.msel = MSEL_HI;
            ST_SUM0:   ctrl.acc_load = 1'b1;
            ST_SUM: begin
                ctrl.rot_raw  = 1'b1;
                ctrl.acc_add  = (r_cnt != CNTW'(SLOW_BARS - 1));
            end
            ST_BAND:   ctrl.rot_band = 1'b1;
            default:   ctrl.msel = MSEL_LIN;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_fast      <= FAST_COEFF_RST;
            r_slow      <= SLOW_COEFF_RST;
            r_margin    <= BAND_MARGIN_RST;
            r_warm      <= '0;
            r_flag      <= 1'b0;
            r_filt      <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_FAST_COEFF)  r_fast   <= i_cfg_data[15:0];
                if (i_cfg_index == CFG_SLOW_COEFF)  r_slow   <= i_cfg_data[15:0];
                if (i_cfg_index == CFG_BAND_MARGIN) r_margin <= i_cfg_data;
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
                r_filt      <= filt;
                if (filt > r_filt) r_flag <= 1'b0;
                else if (filt < r_filt) r_flag <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_fire && r_warm < WU_LIM) r_warm <= r_warm + 1'b1;
            else if (r_state == ST_UPD && r_warm == WU_LIM) r_warm <= r_warm + 1'b1;
        end
    end

    // Histories: rotate during sweeps, push once the bar completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LOOKBACK_BARS; i++) r_ch[i] <= '0;
            for (int i = 0; i < SLOW_BARS; i++) r_rh[i] <= '0;
            for (int i = 0; i < BAND_BARS; i++) begin
                r_hh[i] <= '0;
                r_lh[i] <= '0;
            end
        end else if (r_state == ST_FIN && out_free) begin
            r_ch[0] <= r_bar.close_price;
            r_rh[0] <= r_new;
            r_hh[0] <= r_bar.high_price;
            r_lh[0] <= r_bar.low_price;
            for (int i = 1; i < LOOKBACK_BARS; i++) r_ch[i] <= r_ch[i-1];
            for (int i = 1; i < SLOW_BARS; i++) r_rh[i] <= r_rh[i-1];
            for (int i = 1; i < BAND_BARS; i++) begin
                r_hh[i] <= r_hh[i-1];
                r_lh[i] <= r_lh[i-1];
            end
        end else begin
            if (ctrl.rot_close)
                for (int i = 0; i < LOOKBACK_BARS; i++)
                    r_ch[i] <= r_ch[(i == LOOKBACK_BARS - 1) ? 0 : i + 1];
            if (ctrl.rot_raw)
                for (int i = 0; i < SLOW_BARS; i++)
                    r_rh[i] <= r_rh[(i == SLOW_BARS - 1) ? 0 : i + 1];
            if (ctrl.rot_band)
                for (int i = 0; i < BAND_BARS; i++) begin
                    r_hh[i] <= r_hh[(i == BAND_BARS - 1) ? 0 : i + 1];
                    r_lh[i] <= r_lh[(i == BAND_BARS - 1) ? 0 : i + 1];
                end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bar       <= i_in_data;
            r_new       <= {i_in_data.close_price, 16'd0};
            r_filter_on <= 1'b0;
            r_small     <= 1'b0;
        end
        if (ctrl.acc_load) r_acc <= AW'(ad_out);
        else if (ctrl.acc_add) r_acc <= r_acc + AW'(ad_out);

        // The step sweep counter runs up through the history sweeps and down in the divider,
        // which starts at 16 when the noise sweep ends.
        unique case (r_state)
            ST_NOISE:         r_cnt <= (n_state == ST_DIV) ? CNTW'(16) : r_cnt + 1'b1;
            ST_SUM, ST_BAND:  r_cnt <= r_cnt + 1'b1;
            ST_DIV:           r_cnt <= r_cnt - 1'b1;
            default:          r_cnt <= '0;
        endcase

        if (r_state == ST_NOISE0) begin
            r_signal <= (r_bar.close_price > r_ch[LOOKBACK_BARS-1]) ?
                        (r_bar.close_price - r_ch[LOOKBACK_BARS-1]) :
                        (r_ch[LOOKBACK_BARS-1] - r_bar.close_price);
            r_up  <= ({r_bar.close_price, 16'd0} >= r_rh[0]);
            r_mag <= ({r_bar.close_price, 16'd0} >= r_rh[0]) ?
                     ({r_bar.close_price, 16'd0} - r_rh[0]) :
                     (r_rh[0] - {r_bar.close_price, 16'd0});
        end
        if (r_state == ST_NOISE && n_state == ST_DIV) begin
            r_noise <= r_acc[NW-1:0];
            r_rem   <= NW'(r_signal >> 1);
        end
        if (r_state == ST_DIV) begin
            if (rem2 >= {1'b0, r_noise}) begin
                r_rem <= NW'(rem2 - {1'b0, r_noise});
                r_quo <= {r_quo[15:0], 1'b1};
            end else begin
                r_rem <= rem2[NW-1:0];
                r_quo <= {r_quo[15:0], 1'b0};
            end
        end
        // A zero noise sum means a flat window: ER is zero.
        if (r_state == ST_LIN)
            r_lin <= {r_slow, 16'd0} + ((r_noise == '0) ? 32'd0 : m_p[31:0]);
        if (r_state == ST_SQ)  r_sc    <= sq_rnd[64:48];
        if (r_state == ST_MLO) r_pp_lo <= m_p[40:0];
        if (r_state == ST_MHI) r_pp_hi <= m_p[40:0];
        if (r_state == ST_UPD) begin
            r_new       <= r_up ? (r_rh[0] + step[47:0]) : (r_rh[0] - step[47:0]);
            r_filter_on <= (r_warm > WU_LIM);
        end
        if (r_state == ST_SUM0) r_ad <= ad_out;
        if (r_state == ST_SMALL) begin
            r_small <= (ad_scaled < SMW'(r_acc));
            r_maxh  <= '0;
            r_minl  <= '1;
        end
        if (r_state == ST_BAND) begin
            if (r_hh[0] > r_maxh) r_maxh <= r_hh[0];
            if (r_lh[0] < r_minl) r_minl <= r_lh[0];
        end
        if (r_state == ST_FIN && out_free) begin
            r_out.raw_average      <= r_new;
            r_out.filtered_average <= filt;
            r_out.trend_flag       <= (filt > r_filt) ? 1'b0 :
                                      (filt < r_filt) ? 1'b1 : r_flag;
        end
    end

endmodule
